// File: sv/rfpcp_pkg.sv
// Shared types and constants for the radar frame point cloud parser.
`timescale 1ns / 1ps
`default_nettype none
package rfpcp_pkg;
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_HEADER,
		PH_LENGTH,
		PH_UNITS,
		PH_POINTS
	} phase_t;

	localparam int NUM_UNITS   = 5;
	localparam int MAGIC_LEN   = 8;
	localparam int TLV_LEN_AT  = 52;
	localparam int UNIT_AT     = 56;
	localparam int POINT_START = 76;
	localparam int POINT_BYTES = 8;
	localparam int LEN_BASE    = 28;
	localparam int QDEPTH      = 4;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);
	localparam logic [7:0] SIGN_BYTE = 8'h80;

	typedef struct packed {
		logic [NUM_UNITS-1:0][15:0] vals;
		logic [NUM_UNITS-1:0][31:0] units;
		logic [9:0]                 num;
		logic                       last;
	} point_t;

	typedef struct packed {
		logic              full;
		logic              empty;
		logic [QCNT_W-1:0] count;
	} q_status_t;

	function automatic logic [7:0] magic_byte(input logic [2:0] i);
		logic [7:0] r;
		unique case (i)
			3'd0: r = 8'd2;
			3'd1: r = 8'd1;
			3'd2: r = 8'd4;
			3'd3: r = 8'd3;
			3'd4: r = 8'd6;
			3'd5: r = 8'd5;
			3'd6: r = 8'd8;
			default: r = 8'd7;
		endcase
		return r;
	endfunction
endpackage
`default_nettype wire

// File: sv/rfpcp_front.sv
// Byte parser: magic hunt, header skip, length and unit capture, point assembly.
`timescale 1ns / 1ps
`default_nettype none
module rfpcp_front import rfpcp_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] data_byte,
	output logic            push,
	output point_t          entry
);
	phase_t                             phase_q, phase_d;
	logic [6:0]                         off_q, off_d;
	logic [31:0]                        len_q, len_d;
	logic [10:0]                        expect_q, expect_d;
	logic [10:0]                        done_q, done_d;
	logic [NUM_UNITS-1:0][31:0]         units_q, units_d;
	logic [POINT_BYTES-2:0][7:0]        pb_q, pb_d;
	logic [32:0]                        diff;
	logic [28:0]                        nq;
	logic [4:0]                         rel;
	logic                               last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			off_q    <= '0;
			len_q    <= '0;
			expect_q <= '0;
			done_q   <= '0;
		end else begin
			phase_q  <= phase_d;
			off_q    <= off_d;
			len_q    <= len_d;
			expect_q <= expect_d;
			done_q   <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		units_q <= units_d;
		pb_q    <= pb_d;
	end

	always_comb begin
		last = ({1'b0, done_q} + 12'd1) >= {1'b0, expect_q};
		entry.vals[0] = {{8{pb_q[0][7]}}, pb_q[0]};
		entry.vals[1] = {{8{pb_q[1][7]}}, pb_q[1]};
		entry.vals[2] = {pb_q[3], pb_q[2]};
		entry.vals[3] = {pb_q[5], pb_q[4]};
		entry.vals[4] = {data_byte, pb_q[6]};
		entry.units   = units_q;
		entry.num     = done_q[9:0];
		entry.last    = last;
	end

	always_comb begin
		phase_d  = phase_q;
		off_d    = off_q;
		len_d    = len_q;
		expect_d = expect_q;
		done_d   = done_q;
		units_d  = units_q;
		pb_d     = pb_q;
		push     = 1'b0;
		rel      = 5'(off_q - 7'(UNIT_AT));
		diff     = '0;
		nq       = '0;
		if (take) begin
			unique case (phase_q)
				PH_HEADER: begin
					off_d = off_q + 7'd1;
					if (off_d >= 7'(TLV_LEN_AT)) begin
						phase_d = PH_LENGTH;
						len_d   = '0;
					end
				end
				PH_LENGTH: begin
					len_d = len_q | (32'(data_byte) << {off_q[1:0], 3'b000});
					off_d = off_q + 7'd1;
					if (off_d >= 7'(UNIT_AT)) begin
						phase_d = PH_UNITS;
						diff    = {1'b0, len_d} - 33'(LEN_BASE);
						if (len_d > 32'(LEN_BASE))
							nq = diff[31:3];
						if (nq > 29'(MAX_POINTS))
							nq = 29'(MAX_POINTS);
						expect_d = nq[10:0];
					end
				end
				PH_UNITS: begin
					units_d[rel[4:2]][{rel[1:0], 3'b000} +: 8] = data_byte;
					off_d = off_q + 7'd1;
					if (off_d >= 7'(POINT_START)) begin
						off_d = '0;
						if (expect_q == '0) begin
							phase_d = PH_HUNT;
						end else begin
							phase_d = PH_POINTS;
							done_d  = '0;
						end
					end
				end
				PH_POINTS: begin
					if (off_q < 7'(POINT_BYTES - 1)) begin
						pb_d[off_q[2:0]] = data_byte;
						off_d = off_q + 7'd1;
					end else begin
						push   = 1'b1;
						done_d = done_q + 11'd1;
						off_d  = '0;
						if (last)
							phase_d = PH_HUNT;
					end
				end
				default: begin
					phase_d = PH_HUNT;
					if (off_q < 7'(MAGIC_LEN) && data_byte == magic_byte(off_q[2:0])) begin
						off_d = off_q + 7'd1;
						if (off_d >= 7'(MAGIC_LEN))
							phase_d = PH_HEADER;
					end else begin
						off_d = (data_byte == magic_byte(3'd0)) ? 7'd1 : 7'd0;
					end
				end
			endcase
		end
	end
endmodule
`default_nettype wire

// File: sv/rfpcp_queue.sv
// Short point queue between the parser and the multiply pipeline.
`timescale 1ns / 1ps
`default_nettype none
module rfpcp_queue import rfpcp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  point_t    wr_data,
	input  wire logic pop,
	output point_t    rd_data,
	output q_status_t status
);
	point_t            mem [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + QPTR_W'(1);
			if (pop)
				rd_q <= rd_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push) - QCNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= wr_data;
	end

	assign rd_data      = mem[rd_q];
	assign status.count = cnt_q;
	assign status.full  = cnt_q == QCNT_W'(QDEPTH);
	assign status.empty = cnt_q == '0;
endmodule
`default_nettype wire

// File: sv/rfpcp_fmul.sv
// Four-stage integer by float32 multiply with round to nearest even.
`timescale 1ns / 1ps
`default_nettype none
module rfpcp_fmul (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [15:0] v,
	input  wire logic [31:0] u,
	output logic      [31:0] res
);
	logic        spec_s1, spec_s2, spec_s3;
	logic [31:0] sres_s1, sres_s2, sres_s3;
	logic        sign_s1, sign_s2, sign_s3;
	logic [15:0] mag_s1;
	logic [23:0] mu_s1;
	logic [7:0]  eu_s1, eu_s2, eu_s3;
	logic [39:0] p_s2, p_s3;
	logic [5:0]  l_s3;

	logic        s_nan, s_inf, s_zero, vz;
	logic [31:0] s_res;
	logic [5:0]  lz;
	logic signed [9:0] ex;
	logic [4:0]  sh;
	logic [39:0] shifted, remv, half;
	logic [24:0] mant;
	logic        rnd;
	logic [31:0] r;

	always_comb begin
		vz     = v == '0;
		s_nan  = u[30:23] == 8'hFF && u[22:0] != '0;
		s_inf  = u[30:0] == 31'h7F800000;
		s_zero = vz || u[30:0] == '0;
		s_res  = {u[31] ^ v[15], 31'd0};
		if (s_nan)
			s_res = u | 32'h00400000;
		else if (s_inf)
			s_res = vz ? 32'h7FC00000 : {u[31] ^ v[15], 31'h7F800000};
	end

	always_comb begin
		lz = '0;
		for (int i = 0; i < 40; i++)
			if (p_s2[i])
				lz = 6'(i);
	end

	always_comb begin
		ex      = $signed({2'b00, eu_s3}) + $signed({4'b0000, l_s3}) - 10'sd23;
		sh      = '0;
		shifted = '0;
		remv    = '0;
		half    = '0;
		rnd     = 1'b0;
		mant    = '0;
		r       = '0;
		if (l_s3 > 6'd23) begin
			sh      = 5'(l_s3 - 6'd23);
			shifted = p_s3 >> sh;
			remv    = p_s3 & ((40'd1 << sh) - 40'd1);
			half    = 40'd1 << (sh - 5'd1);
			rnd     = remv > half || (remv == half && shifted[0]);
			mant    = {1'b0, shifted[23:0]} + 25'(rnd);
			if (mant[24]) begin
				ex   = ex + 10'sd1;
				mant = '0;
			end
			if (ex >= 10'sd255)
				r = {sign_s3, 31'h7F800000};
			else
				r = {sign_s3, ex[7:0], mant[22:0]};
		end else if (ex >= 10'sd1) begin
			shifted = p_s3 << (6'd23 - l_s3);
			r       = {sign_s3, ex[7:0], shifted[22:0]};
		end else begin
			shifted = p_s3 << (eu_s3 - 8'd1);
			r       = {sign_s3, 8'd0, shifted[22:0]};
		end
		if (spec_s3)
			r = sres_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spec_s1 <= s_nan || s_inf || s_zero;
			sres_s1 <= s_res;
			sign_s1 <= u[31] ^ v[15];
			mag_s1  <= v[15] ? 16'(-v) : v;
			mu_s1   <= {u[30:23] != '0, u[22:0]};
			eu_s1   <= (u[30:23] == '0) ? 8'd1 : u[30:23];
			spec_s2 <= spec_s1;
			sres_s2 <= sres_s1;
			sign_s2 <= sign_s1;
			eu_s2   <= eu_s1;
			p_s2    <= 40'(mag_s1) * 40'(mu_s1);
			spec_s3 <= spec_s2;
			sres_s3 <= sres_s2;
			sign_s3 <= sign_s2;
			eu_s3   <= eu_s2;
			p_s3    <= p_s2;
			l_s3    <= lz;
			res     <= r;
		end
	end
endmodule
`default_nettype wire

// File: sv/rfpcp_back.sv
// Multiply pipeline: five lanes scale a queued point, output register at the end.
`timescale 1ns / 1ps
`default_nettype none
module rfpcp_back import rfpcp_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_empty,
	input  point_t                    q_data,
	output logic                      pop,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [NUM_UNITS-1:0][31:0] vals,
	output logic [9:0]                num,
	output logic                      last
);
	logic       adv;
	logic       valid_s1, valid_s2, valid_s3, valid_s4;
	logic [9:0] num_s1, num_s2, num_s3, num_s4;
	logic       last_s1, last_s2, last_s3, last_s4;

	assign adv = !valid_s4 || !out_stall;
	assign pop = adv && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= pop;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s1  <= q_data.num;
			last_s1 <= q_data.last;
			num_s2  <= num_s1;
			last_s2 <= last_s1;
			num_s3  <= num_s2;
			last_s3 <= last_s2;
			num_s4  <= num_s3;
			last_s4 <= last_s3;
		end
	end

	for (genvar g = 0; g < NUM_UNITS; g++) begin : g_lane
		rfpcp_fmul u_fmul (
			.clk (clk),
			.en  (adv),
			.v   (q_data.vals[g]),
			.u   (q_data.units[g]),
			.res (vals[g])
		);
	end

	assign out_valid = valid_s4;
	assign num       = num_s4;
	assign last      = last_s4;
endmodule
`default_nettype wire

// File: sv/radar_frame_point_cloud_parser.sv
// Radar UART frame parser: takes one byte per cycle, finds the magic word, reads
// the TLV length and five float32 units, and emits one scaled result per 8-byte
// point. A byte is taken every cycle while the four-entry point queue has room;
// each point passes through the registered stages of the five-lane multiply
// pipeline after it is dequeued, and the pipeline accepts a new point every
// cycle when the output is not stalled. There is no start-up clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module radar_frame_point_cloud_parser import rfpcp_pkg::*; #(
	parameter int MAX_POINTS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [31:0] elevation_value,
	output logic      [31:0] azimuth_value,
	output logic      [31:0] doppler_value,
	output logic      [31:0] range_value,
	output logic      [31:0] snr_value,
	output logic      [9:0]  point_number,
	output logic             last_point
);
	logic                       take, push, pop;
	point_t                     wr_entry, rd_entry;
	q_status_t                  qst;
	logic [NUM_UNITS-1:0][31:0] vals;

	assign in_stall = qst.full;
	assign take     = in_valid && !in_stall;

	rfpcp_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.push      (push),
		.entry     (wr_entry)
	);

	rfpcp_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_entry),
		.pop     (pop),
		.rd_data (rd_entry),
		.status  (qst)
	);

	rfpcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (qst.empty),
		.q_data    (rd_entry),
		.pop       (pop),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.vals      (vals),
		.num       (point_number),
		.last      (last_point)
	);

	assign elevation_value = vals[0];
	assign azimuth_value   = vals[1];
	assign doppler_value   = vals[2];
	assign range_value     = vals[3];
	assign snr_value       = vals[4];

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		qst.count <= QCNT_W'(QDEPTH))
		else $error("point queue count exceeds depth");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !qst.empty)
		else $error("pop from empty point queue");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(point_number))
		else $error("stalled result dropped");
`endif
endmodule
`default_nettype wire
